// ===== design/rbas_pkg.sv =====
// Shared constants, types and helper functions for the block-average ASCII shader.
package rbas_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int MAX_BLOCK  = 64;
	localparam int NUM_SHADES = 10;

	// Configuration port
	localparam int CFG_DATA_W  = 13;
	localparam int CFG_IDX_W   = 2;
	localparam int BS_CFG_W    = 7;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd2;

	// Datapath widths
	localparam int DIM_W   = CFG_DATA_W;
	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_HEIGHT);
	localparam int BS_W    = $clog2(MAX_BLOCK + 1);
	localparam int CIB_W   = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
	localparam int N_W     = $clog2(MAX_BLOCK * MAX_BLOCK + 1);
	localparam int SUM_W   = 20;
	localparam int LUMA_W  = 8;
	localparam int LUMA_MAX = 255;
	localparam int COLOR_W = 8;
	localparam int WEIGHT_W = 16;
	localparam int LUMA_ACC_W = WEIGHT_W + COLOR_W + 2;
	localparam int GLYPH_W = 8;

	localparam logic [WEIGHT_W-1:0] W_RED   = 16'd19595;
	localparam logic [WEIGHT_W-1:0] W_GREEN = 16'd38470;
	localparam logic [WEIGHT_W-1:0] W_BLUE  = 16'd7471;

	// Shade thresholds: one per shade boundary
	localparam int NUM_THR  = NUM_SHADES - 1;
	localparam int SHADE_W  = $clog2(NUM_SHADES);
	localparam int DIV_STEPS = DIM_W;
	localparam int STEP_MAX = (DIV_STEPS > NUM_THR) ? DIV_STEPS : NUM_THR;
	localparam int STEP_W   = (STEP_MAX > 1) ? $clog2(STEP_MAX) : 1;

	localparam logic [GLYPH_W-1:0] GLYPH_CR = 8'd13;
	localparam logic [GLYPH_W-1:0] GLYPH_LF = 8'd10;

	typedef enum logic [1:0] {
		SEL_SHADE,
		SEL_CR,
		SEL_LF
	} glyph_sel_t;

	typedef struct packed {
		logic              div_load;
		logic              div_step;
		logic              dims_load;
		logic              thr_step;
		logic [STEP_W-1:0] step;
		logic              pix_read;
		logic              luma_load;
		logic              accum;
		logic              out_load;
		glyph_sel_t        out_sel;
	} cmd_t;

	typedef struct packed {
		logic emit;      // current pixel closes a whole block
		logic eol;       // latched: that block ends its block row
		logic out_free;  // output register can take a result
	} status_t;

	// Smallest average that reaches shade (step+1): ceil(255*k/NUM_SHADES)
	function automatic logic [LUMA_W-1:0] thr_level(input logic [STEP_W-1:0] step);
		logic [LUMA_W-1:0] t;
		t = '0;
		for (int k = 1; k <= NUM_THR; k++) begin
			if (step == STEP_W'(k - 1)) begin
				t = LUMA_W'((LUMA_MAX * k + NUM_SHADES - 1) / NUM_SHADES);
			end
		end
		return t;
	endfunction

	function automatic logic [GLYPH_W-1:0] shade_glyph(input logic [SHADE_W-1:0] shade);
		logic [GLYPH_W-1:0] g;
		case (shade)
			4'd0: g = 8'h23;    // '#'
			4'd1: g = 8'h24;    // '$'
			4'd2: g = 8'h4F;    // 'O'
			4'd3: g = 8'h3D;    // '='
			4'd4: g = 8'h2B;    // '+'
			4'd5: g = 8'h7C;    // '|'
			4'd6: g = 8'h2D;    // '-'
			4'd7: g = 8'h5E;    // '^'
			4'd8: g = 8'h2E;    // '.'
			default: g = 8'h20; // ' '
		endcase
		return g;
	endfunction

endpackage

// ===== design/rbas_pix_if.sv =====
// Pixel request channel: valid/ready with one RGB pixel.
interface rbas_pix_if;
	logic                        valid;
	logic                        ready;
	logic [rbas_pkg::COLOR_W-1:0] red;
	logic [rbas_pkg::COLOR_W-1:0] green;
	logic [rbas_pkg::COLOR_W-1:0] blue;

	modport source(output valid, output red, output green, output blue, input ready);
	modport sink(input valid, input red, input green, input blue, output ready);
endinterface

// ===== design/rbas_glyph_if.sv =====
// Character request channel: valid/ready with one glyph.
interface rbas_glyph_if;
	logic                        valid;
	logic                        ready;
	logic [rbas_pkg::GLYPH_W-1:0] glyph;
	logic                        last_of_run;

	modport source(output valid, output glyph, output last_of_run, input ready);
	modport sink(input valid, input glyph, input last_of_run, output ready);
endinterface

// ===== design/rbas_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rbas_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== design/rbas_ctrl.sv =====
// Controller: setup sequencing after reset/config and per-pixel sequencing.
module rbas_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  pix_valid,
	output logic                  pix_ready,
	input  rbas_pkg::status_t     status,
	output rbas_pkg::cmd_t        cmd
);
	typedef enum logic [9:0] {
		S_SETUP_LOAD = 10'b0000000001,
		S_SETUP_DIV  = 10'b0000000010,
		S_SETUP_DIMS = 10'b0000000100,
		S_SETUP_THR  = 10'b0000001000,
		S_IDLE       = 10'b0000010000,
		S_LUMA       = 10'b0000100000,
		S_ACCUM      = 10'b0001000000,
		S_CHAR       = 10'b0010000000,
		S_CR         = 10'b0100000000,
		S_LF         = 10'b1000000000
	} state_t;

	state_t                      state_q, state_d;
	logic [rbas_pkg::STEP_W-1:0] step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SETUP_LOAD;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		step_d    = step_q;
		cmd       = '0;
		cmd.step  = step_q;
		cmd.out_sel = rbas_pkg::SEL_SHADE;
		pix_ready = 1'b0;
		case (state_q)
			S_SETUP_LOAD: begin
				cmd.div_load = 1'b1;
				step_d  = '0;
				state_d = S_SETUP_DIV;
			end
			S_SETUP_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == rbas_pkg::STEP_W'(rbas_pkg::DIV_STEPS - 1)) begin
					step_d  = '0;
					state_d = S_SETUP_DIMS;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			S_SETUP_DIMS: begin
				cmd.dims_load = 1'b1;
				step_d  = '0;
				state_d = S_SETUP_THR;
			end
			S_SETUP_THR: begin
				cmd.thr_step = 1'b1;
				if (step_q == rbas_pkg::STEP_W'(rbas_pkg::NUM_THR - 1)) begin
					step_d  = '0;
					state_d = S_IDLE;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			S_IDLE: begin
				pix_ready = !cfg_we;
				if (pix_valid && !cfg_we) begin
					cmd.pix_read = 1'b1;
					state_d = S_LUMA;
				end
			end
			S_LUMA: begin
				cmd.luma_load = 1'b1;
				state_d = S_ACCUM;
			end
			S_ACCUM: begin
				cmd.accum = 1'b1;
				state_d = status.emit ? S_CHAR : S_IDLE;
			end
			S_CHAR: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = rbas_pkg::SEL_SHADE;
					state_d = status.eol ? S_CR : S_IDLE;
				end
			end
			S_CR: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = rbas_pkg::SEL_CR;
					state_d = S_LF;
				end
			end
			S_LF: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = rbas_pkg::SEL_LF;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_SETUP_LOAD;
			end
		endcase
		// any register write reruns the setup with the new values
		if (cfg_we) begin
			state_d = S_SETUP_LOAD;
			step_d  = '0;
		end
	end

	a_single_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && pix_ready) |=> !pix_ready)
		else $error("pixel request accepted while previous one in flight");

	a_lf_after_cr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LF) |-> ($past(state_q) == S_CR || $past(state_q) == S_LF))
		else $error("LF issued without preceding CR");
endmodule

// ===== design/rbas_dpath.sv =====
// Datapath: config registers, setup divider, luma, block sums and output register.
module rbas_dpath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rbas_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rbas_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [rbas_pkg::COLOR_W-1:0]      red,
	input  logic [rbas_pkg::COLOR_W-1:0]      green,
	input  logic [rbas_pkg::COLOR_W-1:0]      blue,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [rbas_pkg::GLYPH_W-1:0]      glyph,
	output logic                              last_of_run,
	input  rbas_pkg::cmd_t                    cmd,
	output rbas_pkg::status_t                 status
);
	localparam int THR_PROD_W = rbas_pkg::LUMA_W + rbas_pkg::N_W;
	localparam int DIMS_PROD_W = rbas_pkg::DIM_W + rbas_pkg::BS_W;

	// configuration
	logic [rbas_pkg::DIM_W-1:0]    fw_q, fh_q;
	logic [rbas_pkg::BS_CFG_W-1:0] bs_q;
	logic [rbas_pkg::DIM_W-1:0]    w_eff, h_eff;
	logic [rbas_pkg::BS_W-1:0]     bs_eff;

	// setup results
	logic [rbas_pkg::DIM_W-1:0]  num_w_q, num_h_q;
	logic [rbas_pkg::BS_W-1:0]   rem_w_q, rem_h_q;
	logic [rbas_pkg::BS_W:0]     trial_w, trial_h;
	logic                        ge_w, ge_h;
	logic [rbas_pkg::DIM_W-1:0]  bpr_q, whole_rows_q;
	logic [rbas_pkg::N_W-1:0]    n_q;
	logic [rbas_pkg::SUM_W-1:0]  thr_q [rbas_pkg::NUM_THR];
	logic [THR_PROD_W-1:0]       thr_prod;
	logic [DIMS_PROD_W-1:0]      rows_prod;

	// raster state
	logic [rbas_pkg::COL_W-1:0] pc_q, bc_q;
	logic [rbas_pkg::ROW_W-1:0] pr_q;
	logic [rbas_pkg::CIB_W-1:0] cib_q, rib_q;
	logic [rbas_pkg::BS_W-1:0]  cib_inc, rib_inc;
	logic [rbas_pkg::DIM_W-1:0] pc_inc, pr_inc, bc_inc;

	// pixel path
	logic [rbas_pkg::COLOR_W-1:0]    r_q, g_q, b_q;
	logic [rbas_pkg::LUMA_ACC_W-1:0] luma_acc;
	logic [rbas_pkg::LUMA_W-1:0]     luma_q;
	logic [rbas_pkg::SUM_W-1:0]      ram_rdata, sum;
	logic                            active, last_blk, first_px, ram_we, eol_q;
	logic [rbas_pkg::SHADE_W-1:0]    shade_cnt, shade_q;

	// output register
	logic                         out_valid_q, last_q;
	logic [rbas_pkg::GLYPH_W-1:0] glyph_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= rbas_pkg::DIM_W'(1);
			fh_q <= rbas_pkg::DIM_W'(1);
			bs_q <= rbas_pkg::BS_CFG_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				rbas_pkg::REG_FRAME_WIDTH:  fw_q <= cfg_data;
				rbas_pkg::REG_FRAME_HEIGHT: fh_q <= cfg_data;
				rbas_pkg::REG_BLOCK_SIZE:   bs_q <= cfg_data[rbas_pkg::BS_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// zero acts as one, oversize clamps to the maximum
	always_comb begin
		if (fw_q == '0) w_eff = rbas_pkg::DIM_W'(1);
		else if (fw_q > rbas_pkg::DIM_W'(rbas_pkg::MAX_WIDTH)) w_eff = rbas_pkg::DIM_W'(rbas_pkg::MAX_WIDTH);
		else w_eff = fw_q;
		if (fh_q == '0) h_eff = rbas_pkg::DIM_W'(1);
		else if (fh_q > rbas_pkg::DIM_W'(rbas_pkg::MAX_HEIGHT)) h_eff = rbas_pkg::DIM_W'(rbas_pkg::MAX_HEIGHT);
		else h_eff = fh_q;
		if (bs_q == '0) bs_eff = rbas_pkg::BS_W'(1);
		else if (rbas_pkg::BS_W'(bs_q) > rbas_pkg::BS_W'(rbas_pkg::MAX_BLOCK)) bs_eff = rbas_pkg::BS_W'(rbas_pkg::MAX_BLOCK);
		else bs_eff = rbas_pkg::BS_W'(bs_q);
	end

	// restoring divider: width/bs and height/bs, one quotient bit a cycle
	assign trial_w = {rem_w_q, num_w_q[rbas_pkg::DIM_W-1]};
	assign trial_h = {rem_h_q, num_h_q[rbas_pkg::DIM_W-1]};
	assign ge_w = trial_w >= {1'b0, bs_eff};
	assign ge_h = trial_h >= {1'b0, bs_eff};

	assign rows_prod = DIMS_PROD_W'(num_h_q) * DIMS_PROD_W'(bs_eff);
	assign thr_prod  = THR_PROD_W'(rbas_pkg::thr_level(cmd.step)) * THR_PROD_W'(n_q);

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			num_w_q <= w_eff;
			num_h_q <= h_eff;
			rem_w_q <= '0;
			rem_h_q <= '0;
		end else if (cmd.div_step) begin
			num_w_q <= {num_w_q[rbas_pkg::DIM_W-2:0], ge_w};
			num_h_q <= {num_h_q[rbas_pkg::DIM_W-2:0], ge_h};
			rem_w_q <= ge_w ? rbas_pkg::BS_W'(trial_w - {1'b0, bs_eff})
			                : trial_w[rbas_pkg::BS_W-1:0];
			rem_h_q <= ge_h ? rbas_pkg::BS_W'(trial_h - {1'b0, bs_eff})
			                : trial_h[rbas_pkg::BS_W-1:0];
		end
		if (cmd.dims_load) begin
			bpr_q        <= num_w_q;
			whole_rows_q <= rows_prod[rbas_pkg::DIM_W-1:0];
			n_q          <= rbas_pkg::N_W'(bs_eff) * rbas_pkg::N_W'(bs_eff);
		end
		// thresholds shift in from the top; thr_q[0] ends as the first boundary
		if (cmd.thr_step) begin
			for (int i = 0; i < rbas_pkg::NUM_THR - 1; i++) begin
				thr_q[i] <= thr_q[i+1];
			end
			thr_q[rbas_pkg::NUM_THR-1] <= thr_prod[rbas_pkg::SUM_W-1:0];
		end
	end

	// pixel capture and luma
	assign luma_acc = rbas_pkg::LUMA_ACC_W'(rbas_pkg::W_RED) * rbas_pkg::LUMA_ACC_W'(r_q)
	                + rbas_pkg::LUMA_ACC_W'(rbas_pkg::W_GREEN) * rbas_pkg::LUMA_ACC_W'(g_q)
	                + rbas_pkg::LUMA_ACC_W'(rbas_pkg::W_BLUE) * rbas_pkg::LUMA_ACC_W'(b_q);

	always_ff @(posedge clk) begin
		if (cmd.pix_read) begin
			r_q <= red;
			g_q <= green;
			b_q <= blue;
		end
		if (cmd.luma_load) begin
			luma_q <= luma_acc[rbas_pkg::WEIGHT_W +: rbas_pkg::LUMA_W];
		end
	end

	rbas_ram #(
		.WIDTH(rbas_pkg::SUM_W),
		.DEPTH(rbas_pkg::MAX_WIDTH)
	) u_sums (
		.clk  (clk),
		.we   (ram_we),
		.waddr(bc_q),
		.wdata(sum),
		.re   (cmd.pix_read),
		.raddr(bc_q),
		.rdata(ram_rdata)
	);

	assign cib_inc = rbas_pkg::BS_W'(cib_q) + 1'b1;
	assign rib_inc = rbas_pkg::BS_W'(rib_q) + 1'b1;
	assign pc_inc  = rbas_pkg::DIM_W'(pc_q) + 1'b1;
	assign pr_inc  = rbas_pkg::DIM_W'(pr_q) + 1'b1;
	assign bc_inc  = rbas_pkg::DIM_W'(bc_q) + 1'b1;

	assign active   = (rbas_pkg::DIM_W'(bc_q) < bpr_q) && (rbas_pkg::DIM_W'(pr_q) < whole_rows_q);
	assign last_blk = (cib_inc >= bs_eff) && (rib_inc >= bs_eff);
	assign first_px = (cib_q == '0) && (rib_q == '0);
	assign sum      = first_px ? rbas_pkg::SUM_W'(luma_q) : ram_rdata + rbas_pkg::SUM_W'(luma_q);
	assign ram_we   = cmd.accum && active;

	// shade = number of boundaries the block sum reaches
	always_comb begin
		shade_cnt = '0;
		for (int k = 0; k < rbas_pkg::NUM_THR; k++) begin
			shade_cnt = shade_cnt + rbas_pkg::SHADE_W'(sum >= thr_q[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accum) begin
			shade_q <= shade_cnt;
			eol_q   <= bc_inc >= bpr_q;
		end
	end

	// raster and block counters advance on every pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= '0;
			pr_q  <= '0;
			cib_q <= '0;
			rib_q <= '0;
			bc_q  <= '0;
		end else if (cmd.accum) begin
			if (pc_inc >= w_eff) begin
				pc_q  <= '0;
				cib_q <= '0;
				bc_q  <= '0;
				if (pr_inc >= h_eff) begin
					pr_q  <= '0;
					rib_q <= '0;
				end else begin
					pr_q  <= pr_inc[rbas_pkg::ROW_W-1:0];
					rib_q <= (rib_inc >= bs_eff) ? '0 : rib_inc[rbas_pkg::CIB_W-1:0];
				end
			end else begin
				pc_q <= pc_inc[rbas_pkg::COL_W-1:0];
				if (cib_inc >= bs_eff) begin
					cib_q <= '0;
					bc_q  <= bc_inc[rbas_pkg::COL_W-1:0];
				end else begin
					cib_q <= cib_inc[rbas_pkg::CIB_W-1:0];
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			case (cmd.out_sel)
				rbas_pkg::SEL_SHADE: begin
					glyph_q <= rbas_pkg::shade_glyph(shade_q);
					last_q  <= !eol_q;
				end
				rbas_pkg::SEL_CR: begin
					glyph_q <= rbas_pkg::GLYPH_CR;
					last_q  <= 1'b0;
				end
				rbas_pkg::SEL_LF: begin
					glyph_q <= rbas_pkg::GLYPH_LF;
					last_q  <= 1'b1;
				end
				default: begin
					glyph_q <= rbas_pkg::GLYPH_LF;
					last_q  <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign glyph       = glyph_q;
	assign last_of_run = last_q;

	assign status.emit     = active && last_blk;
	assign status.eol      = eol_q;
	assign status.out_free = !out_valid_q || out_ready;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("output register overwritten before taken");

	a_ram_ports_apart: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.pix_read && ram_we))
		else $error("block sum read and write in the same cycle");
endmodule

// ===== design/rgb_block_average_ascii_shade.sv =====
// Top level of the block-average ASCII shader.
// RGB pixels come in raster order on the pixel channel; each is reduced to luma and summed
// into a per-block-column sum held in a 4096 x 20 RAM. When a pixel closes a whole block, its
// shade character goes out, followed by CR and LF when the block ends a block row. A pixel
// is accepted, reduced to luma and added into its block sum by a read-modify-write; each
// result it sends waits until the output register is free, and the next pixel is accepted
// only after the last result is loaded. That last result waits in the output register while
// the next pixel is taken. After reset and after every register write the block runs its
// setup (a 13-step serial divide for the block counts, then the shade thresholds one by one)
// with ready low. Results for pixels right of or below the last whole block are dropped.
module rgb_block_average_ascii_shade (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rbas_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rbas_pkg::CFG_DATA_W-1:0] cfg_data,
	rbas_pix_if.sink                        pixels,
	rbas_glyph_if.source                    chars
);
	rbas_pkg::cmd_t    cmd;
	rbas_pkg::status_t status;

	rbas_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.pix_valid(pixels.valid),
		.pix_ready(pixels.ready),
		.status   (status),
		.cmd      (cmd)
	);

	rbas_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.red        (pixels.red),
		.green      (pixels.green),
		.blue       (pixels.blue),
		.out_valid  (chars.valid),
		.out_ready  (chars.ready),
		.glyph      (chars.glyph),
		.last_of_run(chars.last_of_run),
		.cmd        (cmd),
		.status     (status)
	);
endmodule
